// ===== design/tce_pkg.sv =====
// Package for the text console engine: defaults, codes, state type, modifier update.
`default_nettype none
package tce_pkg;

    // Default screen geometry
    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    // Attribute byte that reset fills the screen with
    localparam logic [7:0] RESET_COLOR = 8'h0E;

    // Commands
    localparam logic [1:0] CMD_PUT  = 2'd0;
    localparam logic [1:0] CMD_KEY  = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;

    // Characters
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    // Scan codes
    localparam logic [7:0] KEY_BACKSPACE   = 8'h0E;
    localparam logic [7:0] KEY_TAB         = 8'h0F;
    localparam logic [7:0] KEY_ENTER       = 8'h1C;
    localparam logic [7:0] KEY_LCTRL       = 8'h1D;
    localparam logic [7:0] KEY_LSHIFT      = 8'h2A;
    localparam logic [7:0] KEY_RSHIFT      = 8'h36;
    localparam logic [7:0] KEY_LALT        = 8'h38;
    localparam logic [7:0] KEY_CAPS        = 8'h3A;
    localparam logic [7:0] KEY_NUM         = 8'h45;
    localparam logic [7:0] KEY_SCROLL      = 8'h46;
    localparam logic [7:0] KEY_LCTRL_UP    = 8'h9D;
    localparam logic [7:0] KEY_LSHIFT_UP   = 8'hAA;
    localparam logic [7:0] KEY_RSHIFT_UP   = 8'hB6;

    // Modifier flag bits
    localparam logic [6:0] MOD_LCTRL  = 7'h01;
    localparam logic [6:0] MOD_LSHIFT = 7'h02;
    localparam logic [6:0] MOD_RSHIFT = 7'h04;
    localparam logic [6:0] MOD_LALT   = 7'h08;
    localparam logic [6:0] MOD_CAPS   = 7'h10;
    localparam logic [6:0] MOD_NUM    = 7'h20;
    localparam logic [6:0] MOD_SCROLL = 7'h40;

    // Sequencer states
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_PUT,
        S_NEWLINE,
        S_SCROLL,
        S_SCROLL_END,
        S_BS_STEP,
        S_BS_WAIT,
        S_READ_WAIT,
        S_DONE
    } t_state;

    // Modifier flags after one scan code
    function automatic logic [6:0] f_mod_update(input logic [6:0] mods, input logic [7:0] key);
        logic [6:0] m;
        m = mods;
        case (key)
            KEY_LCTRL:     m = m | MOD_LCTRL;
            KEY_LSHIFT:    m = m | MOD_LSHIFT;
            KEY_RSHIFT:    m = m | MOD_RSHIFT;
            KEY_LALT:      m = m | MOD_LALT;
            KEY_CAPS:      m = m ^ MOD_CAPS;
            KEY_NUM:       m = m ^ MOD_NUM;
            KEY_SCROLL:    m = m ^ MOD_SCROLL;
            KEY_LCTRL_UP:  m = m & ~MOD_LCTRL;
            KEY_LSHIFT_UP: m = m & ~MOD_LSHIFT;
            KEY_RSHIFT_UP: m = m & ~MOD_RSHIFT;
            default:       m = mods;
        endcase
        return m;
    endfunction

endpackage
`default_nettype wire

// ===== design/tce_ram.sv =====
// Generic simple dual-port RAM, one write port, one registered read port.
`default_nettype none
module tce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ===== design/text_console_engine_top.sv =====
// Text console engine top level: sequencer, cursor, modifiers and screen store.
//
// The screen store is one RAM of COLUMNS*ROWS 16-bit cells (attribute byte high,
// character low). After reset a clearing pass writes every cell, one per cycle,
// so the block takes no item until the pass ends; configuration writes are
// taken throughout. Each accepted word goes through a dispatch state, the
// states of its operation and a done state that loads the result registers
// once the output is free. A newline on the last row scrolls: the RAM is
// swept once, one cell per cycle; a tab is four puts and can hold one scroll.
// A backspace walks back one cell at a time until it finds a character or
// reaches the first cell. One result word comes out per input word; a new
// word is accepted while the last result still waits.
`default_nettype none
module text_console_engine_top
    import tce_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int ROWS    = ROWS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [7:0]  i_cfg_wdata,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_command,
    input  wire logic [7:0]  i_char_code,
    input  wire logic [7:0]  i_key_code,
    input  wire logic [10:0] i_cell_index,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [10:0]      o_cursor_position,
    output logic [6:0]       o_modifier_flags,
    output logic [15:0]      o_cell_data
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int FW    = $clog2(CELLS + 1);
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLUMNS + 1);
    localparam int XW    = (FW > 11) ? FW : 11;

    // Registers
    t_state       r_state, n_state;
    logic [7:0]   r_color;
    logic [RW-1:0] r_row, n_row;
    logic [CW-1:0] r_col, n_col;
    logic [FW-1:0] r_flat, n_flat;
    logic [6:0]   r_mods, n_mods;
    logic [FW-1:0] r_cnt, n_cnt;
    logic [1:0]   r_tab_left, n_tab_left;
    logic [7:0]   r_char, n_char;
    logic [1:0]   r_cmd;
    logic [7:0]   r_key;
    logic [10:0]  r_idx;
    logic         r_rd_ok, n_rd_ok;
    logic [15:0]  r_data, n_data;
    logic         r_mv_valid, n_mv_valid;
    logic         r_mv_zero, n_mv_zero;
    logic [AW-1:0] r_mv_addr, n_mv_addr;
    logic         r_out_valid;
    logic [10:0]  r_out_pos;
    logic [6:0]   r_out_mods;
    logic [15:0]  r_out_data;

    // RAM port
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [15:0]   w_wdata;
    logic [AW-1:0] w_raddr;
    logic [15:0]   w_rdata;

    // Shared conditions
    logic w_accept, w_put_wrap, w_last_row, w_origin, w_sweep_last, w_has_char;
    logic w_flat_ok, w_idx_ok, w_op_end, w_out_load, w_is_lf;

    tce_ram #(
        .WIDTH (16),
        .DEPTH (CELLS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_accept     = i_in_valid && o_in_ready;
    assign w_is_lf      = (r_char == CHAR_LF);
    assign w_put_wrap   = (r_col == CW'(COLUMNS - 1));
    assign w_last_row   = (r_row == RW'(ROWS - 1));
    assign w_origin     = (r_flat == '0);
    assign w_sweep_last = (r_cnt == FW'(CELLS - 1));
    assign w_has_char   = (w_rdata[7:0] != CHAR_NUL);
    assign w_flat_ok    = (r_flat < FW'(CELLS));
    assign w_idx_ok     = (XW'(r_idx) < XW'(CELLS));
    assign w_op_end     = ((r_state == S_PUT) && !w_is_lf && !w_put_wrap)
                       || ((r_state == S_NEWLINE) && !w_last_row)
                       || (r_state == S_SCROLL_END);
    assign w_out_load   = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR:      if (w_sweep_last) n_state = S_IDLE;
            S_IDLE:       if (w_accept) n_state = S_DISPATCH;
            S_DISPATCH: begin
                case (r_cmd)
                    CMD_PUT:  n_state = S_PUT;
                    CMD_READ: n_state = S_READ_WAIT;
                    CMD_KEY: begin
                        case (r_key)
                            KEY_BACKSPACE: n_state = S_BS_STEP;
                            KEY_TAB:       n_state = S_PUT;
                            KEY_ENTER:     n_state = S_NEWLINE;
                            default:       n_state = S_DONE;
                        endcase
                    end
                    default:  n_state = S_DONE;
                endcase
            end
            S_PUT: begin
                if (w_is_lf || w_put_wrap) n_state = S_NEWLINE;
                else if (r_tab_left != '0) n_state = S_PUT;
                else n_state = S_DONE;
            end
            S_NEWLINE: begin
                if (w_last_row) n_state = S_SCROLL;
                else if (r_tab_left != '0) n_state = S_PUT;
                else n_state = S_DONE;
            end
            S_SCROLL:     if (w_sweep_last) n_state = S_SCROLL_END;
            S_SCROLL_END: n_state = (r_tab_left != '0) ? S_PUT : S_DONE;
            S_BS_STEP:    n_state = w_origin ? S_DONE : S_BS_WAIT;
            S_BS_WAIT:    n_state = w_has_char ? S_DONE : S_BS_STEP;
            S_READ_WAIT:  n_state = S_DONE;
            S_DONE:       if (w_out_load) n_state = S_IDLE;
            default:      n_state = S_IDLE;
        endcase
    end

    // Datapath and RAM access
    always_comb begin
        n_row      = r_row;
        n_col      = r_col;
        n_flat     = r_flat;
        n_mods     = r_mods;
        n_cnt      = r_cnt;
        n_tab_left = r_tab_left;
        n_char     = r_char;
        n_rd_ok    = r_rd_ok;
        n_data     = r_data;
        n_mv_valid = 1'b0;
        n_mv_zero  = r_mv_zero;
        n_mv_addr  = r_mv_addr;
        w_we       = 1'b0;
        w_waddr    = r_flat[AW-1:0];
        w_wdata    = {r_color, CHAR_NUL};
        w_raddr    = AW'(r_idx);

        // character of a newly accepted word
        if (w_accept) begin
            n_char = i_char_code;
        end

        // pending scroll move lands in the cycle after its read
        if (r_mv_valid) begin
            w_we    = 1'b1;
            w_waddr = r_mv_addr;
            w_wdata = r_mv_zero ? 16'h0000 : w_rdata;
        end

        // a tab keeps putting spaces
        if (w_op_end && (r_tab_left != '0)) begin
            n_tab_left = r_tab_left - 2'd1;
        end

        case (r_state)
            S_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_cnt[AW-1:0];
                w_wdata = {RESET_COLOR, CHAR_NUL};
                n_cnt   = w_sweep_last ? '0 : FW'(r_cnt + 1'b1);
            end
            S_DISPATCH: begin
                n_data     = '0;
                n_tab_left = '0;
                n_rd_ok    = w_idx_ok;
                if (r_cmd == CMD_KEY) begin
                    n_mods = f_mod_update(r_mods, r_key);
                    if (r_key == KEY_TAB) begin
                        n_char     = CHAR_SPACE;
                        n_tab_left = 2'd3;
                    end
                end
            end
            S_PUT: begin
                if (!w_is_lf) begin
                    w_we    = 1'b1;
                    w_wdata = {r_color, r_char};
                    n_col   = CW'(r_col + 1'b1);
                    n_flat  = FW'(r_flat + 1'b1);
                end
            end
            S_NEWLINE: begin
                w_we    = w_flat_ok;
                w_wdata = {r_color, CHAR_SPACE};
                n_col   = '0;
                n_cnt   = '0;
                if (w_last_row) begin
                    n_flat = FW'((ROWS - 1) * COLUMNS);
                end else begin
                    n_row  = RW'(r_row + 1'b1);
                    n_flat = FW'(r_flat - FW'(r_col) + FW'(COLUMNS));
                end
            end
            S_SCROLL: begin
                // read a cell one row down, write it in the next cycle
                w_raddr    = AW'(r_cnt + FW'(COLUMNS));
                n_mv_valid = 1'b1;
                n_mv_addr  = r_cnt[AW-1:0];
                n_mv_zero  = (r_cnt >= FW'(CELLS - COLUMNS));
                n_cnt      = FW'(r_cnt + 1'b1);
            end
            S_BS_STEP: begin
                if (w_origin) begin
                    w_we = 1'b1;
                end else begin
                    if (r_col == '0) begin
                        n_row = RW'(r_row - 1'b1);
                        n_col = CW'(COLUMNS - 1);
                    end else begin
                        n_col = CW'(r_col - 1'b1);
                    end
                    n_flat  = FW'(r_flat - 1'b1);
                    w_raddr = AW'(r_flat - 1'b1);
                end
            end
            S_BS_WAIT: begin
                w_we = w_has_char;
            end
            S_READ_WAIT: begin
                n_data = r_rd_ok ? w_rdata : 16'h0000;
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_color     <= RESET_COLOR;
            r_row       <= '0;
            r_col       <= '0;
            r_flat      <= '0;
            r_mods      <= '0;
            r_cnt       <= '0;
            r_tab_left  <= '0;
            r_mv_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_row      <= n_row;
            r_col      <= n_col;
            r_flat     <= n_flat;
            r_mods     <= n_mods;
            r_cnt      <= n_cnt;
            r_tab_left <= n_tab_left;
            r_mv_valid <= n_mv_valid;
            if (i_cfg_we) begin
                r_color <= i_cfg_wdata;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_char    <= n_char;
        r_rd_ok   <= n_rd_ok;
        r_data    <= n_data;
        r_mv_zero <= n_mv_zero;
        r_mv_addr <= n_mv_addr;
        if (w_accept) begin
            r_cmd  <= i_command;
            r_key  <= i_key_code;
            r_idx  <= i_cell_index;
        end
        if (w_out_load) begin
            r_out_pos  <= 11'(XW'(r_flat));
            r_out_mods <= r_mods;
            r_out_data <= r_data;
        end
    end

    assign o_in_ready        = (r_state == S_IDLE);
    assign o_out_valid       = r_out_valid;
    assign o_cursor_position = r_out_pos;
    assign o_modifier_flags  = r_out_mods;
    assign o_cell_data       = r_out_data;

    // Checks
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_in_ready)
        else $error("input taken during clearing pass");

    a_cursor_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_row < RW'(ROWS - 1) || r_row == RW'(ROWS - 1))
                                && (r_col < CW'(COLUMNS)))
        else $error("cursor outside the screen");

    a_flat_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (32'(r_flat) == 32'(r_row) * COLUMNS + 32'(r_col)))
        else $error("flat cursor out of step with row and column");

    a_move_only_in_scroll: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mv_valid |-> (r_state == S_SCROLL || r_state == S_SCROLL_END))
        else $error("scroll write outside a scroll");

endmodule
`default_nettype wire
